>>> hdl/vaps_pkg.sv
// Shared types, register codes and defaults of the voice activity phrase segmenter.
package vaps_pkg;

  localparam int CHUNK_MAX_DEFAULT = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int BYTES_W     = 24;
  localparam int TIME_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 32;

  // Result word layout, lowest bit first.
  localparam int M_ACTIVE_BIT = 0;
  localparam int M_KEEP_BIT   = 1;
  localparam int M_START_BIT  = 2;
  localparam int M_EMIT_BIT   = 3;
  localparam int M_BYTES_LSB  = 4;
  localparam int M_BYTES_MSB  = M_BYTES_LSB + BYTES_W - 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_GAP_MS    = 3'd1,
    CFG_MIN_BYTES = 3'd2,
    CFG_MAX_BYTES = 3'd3,
    CFG_MODE      = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [15:0]        threshold;
    logic [15:0]        gap_ms;
    logic [BYTES_W-1:0] min_bytes;
    logic [BYTES_W-1:0] max_bytes;
    logic               mode_8bit;
  } cfg_t;

  localparam logic [15:0]        THRESHOLD_RESET = 16'd655;
  localparam logic [15:0]        GAP_MS_RESET    = 16'd1000;
  localparam logic [BYTES_W-1:0] MIN_BYTES_RESET = 24'd32000;
  localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 24'd960000;
  localparam logic [BYTES_W-1:0] BYTES_SAT       = 24'hFFFFFF;

endpackage

>>> hdl/vaps_accum.sv
// Sample magnitude, per-chunk accumulation and the chunk register.
module vaps_accum #(
  parameter int CHUNK_MAX = vaps_pkg::CHUNK_MAX_DEFAULT,
  parameter int CNT_W     = $clog2(CHUNK_MAX + 1),
  parameter int SUM_W     = CNT_W + 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mode_8bit,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vaps_pkg::SAMPLE_W-1:0] sample,
  input  logic                          chunk_last,
  input  logic [vaps_pkg::TIME_W-1:0]   time_ms,
  output logic                          ch_valid,
  input  logic                          ch_ready,
  output logic [SUM_W-1:0]              ch_sum,
  output logic [CNT_W-1:0]              ch_count,
  output logic [vaps_pkg::TIME_W-1:0]   ch_time
);

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count_next;
  logic [15:0]      mag;
  logic [7:0]       dist8;
  logic             take;
  logic             room;

  assign in_ready = !ch_valid || ch_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    dist8 = (sample[7]) ? (sample[7:0] - 8'd128) : (8'd128 - sample[7:0]);
    if (mode_8bit) begin
      mag = {dist8, 8'd0};
    end else if (sample[15]) begin
      // Negation of -32768 wraps to 0x8000, which is the wanted 32768.
      mag = ~sample + 16'd1;
    end else begin
      mag = sample;
    end
  end

  // Samples past the chunk limit are dropped from both sum and count.
  assign room       = count < CNT_W'(CHUNK_MAX);
  assign sum_next   = room ? (sum + SUM_W'(mag)) : sum;
  assign count_next = room ? (count + CNT_W'(1)) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      count    <= '0;
      ch_valid <= 1'b0;
    end else begin
      if (take && chunk_last) begin
        sum      <= '0;
        count    <= '0;
        ch_valid <= 1'b1;
      end else begin
        if (take) begin
          sum   <= sum_next;
          count <= count_next;
        end
        if (ch_ready) begin
          ch_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && chunk_last) begin
      ch_sum   <= sum_next;
      ch_count <= count_next;
      ch_time  <= time_ms;
    end
  end

endmodule

>>> hdl/vaps_detect.sv
// Chunk energy test against the threshold and chunk byte size.
module vaps_detect #(
  parameter int CHUNK_MAX = vaps_pkg::CHUNK_MAX_DEFAULT,
  parameter int CNT_W     = $clog2(CHUNK_MAX + 1),
  parameter int SUM_W     = CNT_W + 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vaps_pkg::cfg_t              cfg,
  input  logic                        ch_valid,
  output logic                        ch_ready,
  input  logic [SUM_W-1:0]            ch_sum,
  input  logic [CNT_W-1:0]            ch_count,
  input  logic [vaps_pkg::TIME_W-1:0] ch_time,
  output logic                        dt_valid,
  input  logic                        dt_ready,
  output logic                        dt_active,
  output logic [CNT_W:0]              dt_bytes,
  output logic [vaps_pkg::TIME_W-1:0] dt_time
);

  logic [SUM_W:0] lhs;
  logic [SUM_W:0] rhs;
  logic           take;

  // 2*sum > threshold*count, i.e. mean/32768 > threshold/65536.
  assign lhs      = {ch_sum, 1'b0};
  assign rhs      = (SUM_W + 1)'(cfg.threshold) * (SUM_W + 1)'(ch_count);
  assign ch_ready = !dt_valid || dt_ready;
  assign take     = ch_valid && ch_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_valid <= 1'b0;
    end else if (take) begin
      dt_valid <= 1'b1;
    end else if (dt_ready) begin
      dt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dt_active <= lhs > rhs;
      dt_bytes  <= cfg.mode_8bit ? {1'b0, ch_count} : {ch_count, 1'b0};
      dt_time   <= ch_time;
    end
  end

endmodule

>>> hdl/vaps_phrase.sv
// Phrase state update and the result register.
module vaps_phrase #(
  parameter int CHUNK_MAX = vaps_pkg::CHUNK_MAX_DEFAULT,
  parameter int CNT_W     = $clog2(CHUNK_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  vaps_pkg::cfg_t                 cfg,
  input  logic                           dt_valid,
  output logic                           dt_ready,
  input  logic                           dt_active,
  input  logic [CNT_W:0]                 dt_bytes,
  input  logic [vaps_pkg::TIME_W-1:0]    dt_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vaps_pkg::M_TDATA_W-1:0] out_data
);

  logic                           capturing;
  logic                           capturing_next;
  logic [vaps_pkg::BYTES_W-1:0]   byte_count;
  logic [vaps_pkg::BYTES_W-1:0]   byte_count_next;
  logic [vaps_pkg::TIME_W-1:0]    last_activity;
  logic [vaps_pkg::BYTES_W-1:0]   base;
  logic [vaps_pkg::BYTES_W:0]     total;
  logic [vaps_pkg::BYTES_W-1:0]   sat;
  logic [vaps_pkg::TIME_W-1:0]    quiet_ms;
  logic                           keep;
  logic                           start;
  logic                           emit;
  logic [vaps_pkg::M_TDATA_W-1:0] data_next;
  logic                           take;

  assign dt_ready = !out_valid || out_ready;
  assign take     = dt_valid && dt_ready;

  always_comb begin
    start    = dt_active && !capturing;
    keep     = dt_active || capturing;
    base     = start ? '0 : byte_count;
    total    = (vaps_pkg::BYTES_W + 1)'(base) + (vaps_pkg::BYTES_W + 1)'(dt_bytes);
    sat      = total[vaps_pkg::BYTES_W] ? vaps_pkg::BYTES_SAT : total[vaps_pkg::BYTES_W-1:0];
    quiet_ms = dt_time - last_activity;
    if (dt_active) begin
      emit = sat > cfg.max_bytes;
    end else begin
      emit = capturing && (quiet_ms > vaps_pkg::TIME_W'(cfg.gap_ms)) && (sat > cfg.min_bytes);
    end
    capturing_next  = emit ? 1'b0 : keep;
    byte_count_next = emit ? '0 : (keep ? sat : byte_count);

    data_next = '0;
    data_next[vaps_pkg::M_ACTIVE_BIT] = dt_active;
    data_next[vaps_pkg::M_KEEP_BIT]   = keep;
    data_next[vaps_pkg::M_START_BIT]  = start;
    data_next[vaps_pkg::M_EMIT_BIT]   = emit;
    data_next[vaps_pkg::M_BYTES_MSB:vaps_pkg::M_BYTES_LSB] = keep ? sat : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      capturing     <= 1'b0;
      byte_count    <= '0;
      last_activity <= '0;
    end else begin
      if (take) begin
        out_valid  <= 1'b1;
        capturing  <= capturing_next;
        byte_count <= byte_count_next;
        if (dt_active) begin
          last_activity <= dt_time;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hdl/voice_activity_phrase_segmenter.sv
// Top level of the voice activity phrase segmenter: registers and stage wiring.
//
//   channel   direction  handshake          payload
//   s_*       in         tvalid / tready    tdata: sample, time_ms; tlast: chunk_last
//   m_*       out        tvalid / tready    tdata: flags and phrase byte count
//   cfg_*     in         valid / ready      cfg_index, cfg_data
//
// One sample is accepted every cycle while s_tready is high. The edge that accepts a chunk's
// last sample loads the chunk register; the energy test register and the result register
// follow in turn, each loaded when the one before it is taken, and the result drives m_tvalid.
// Each stage holds its item while the next one is full, so a stalled m_tready only
// blocks s_tready once all three stages are occupied.
// Reset clears the sums, valid flags and phrase state and loads the configuration defaults.
module voice_activity_phrase_segmenter #(
  parameter int CHUNK_MAX = vaps_pkg::CHUNK_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vaps_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] sample, [47:16] time_ms
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] voice_active, [1] chunk_keep, [2] phrase_start, [3] phrase_emit,
  // [27:4] phrase_bytes, [31:28] zero
  output logic [vaps_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vaps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vaps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(CHUNK_MAX + 1);
  localparam int SUM_W = CNT_W + 15;

  vaps_pkg::cfg_t              cfg;
  logic                        ch_valid;
  logic                        ch_ready;
  logic [SUM_W-1:0]            ch_sum;
  logic [CNT_W-1:0]            ch_count;
  logic [vaps_pkg::TIME_W-1:0] ch_time;
  logic                        dt_valid;
  logic                        dt_ready;
  logic                        dt_active;
  logic [CNT_W:0]              dt_bytes;
  logic [vaps_pkg::TIME_W-1:0] dt_time;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= vaps_pkg::THRESHOLD_RESET;
      cfg.gap_ms    <= vaps_pkg::GAP_MS_RESET;
      cfg.min_bytes <= vaps_pkg::MIN_BYTES_RESET;
      cfg.max_bytes <= vaps_pkg::MAX_BYTES_RESET;
      cfg.mode_8bit <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vaps_pkg::CFG_THRESHOLD: cfg.threshold <= cfg_data[15:0];
        vaps_pkg::CFG_GAP_MS:    cfg.gap_ms    <= cfg_data[15:0];
        vaps_pkg::CFG_MIN_BYTES: cfg.min_bytes <= cfg_data;
        vaps_pkg::CFG_MAX_BYTES: cfg.max_bytes <= cfg_data;
        vaps_pkg::CFG_MODE:      cfg.mode_8bit <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vaps_accum #(
    .CHUNK_MAX(CHUNK_MAX),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .mode_8bit (cfg.mode_8bit),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[15:0]),
    .chunk_last(s_tlast),
    .time_ms   (s_tdata[47:16]),
    .ch_valid  (ch_valid),
    .ch_ready  (ch_ready),
    .ch_sum    (ch_sum),
    .ch_count  (ch_count),
    .ch_time   (ch_time)
  );

  vaps_detect #(
    .CHUNK_MAX(CHUNK_MAX),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W)
  ) u_detect (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ch_valid (ch_valid),
    .ch_ready (ch_ready),
    .ch_sum   (ch_sum),
    .ch_count (ch_count),
    .ch_time  (ch_time),
    .dt_valid (dt_valid),
    .dt_ready (dt_ready),
    .dt_active(dt_active),
    .dt_bytes (dt_bytes),
    .dt_time  (dt_time)
  );

  vaps_phrase #(
    .CHUNK_MAX(CHUNK_MAX),
    .CNT_W    (CNT_W)
  ) u_phrase (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .dt_valid (dt_valid),
    .dt_ready (dt_ready),
    .dt_active(dt_active),
    .dt_bytes (dt_bytes),
    .dt_time  (dt_time),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

endmodule

>>> hdl/vaps_checker.sv
// Port-level checks of the voice activity phrase segmenter and their binding.
module vaps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [vaps_pkg::M_TDATA_W-1:0] m_tdata
);

  // No result may be left pending out of reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A chunk that is dropped reports no phrase activity and a zero size.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[vaps_pkg::M_KEEP_BIT] |->
      !m_tdata[vaps_pkg::M_START_BIT] && !m_tdata[vaps_pkg::M_EMIT_BIT] &&
      m_tdata[vaps_pkg::M_BYTES_MSB:vaps_pkg::M_BYTES_LSB] == '0)
    else $error("dropped chunk carries phrase data");

  // Only a voice-active chunk can open a phrase.
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[vaps_pkg::M_START_BIT] |->
      m_tdata[vaps_pkg::M_ACTIVE_BIT] && m_tdata[vaps_pkg::M_KEEP_BIT])
    else $error("phrase started on a silent chunk");

endmodule

bind voice_activity_phrase_segmenter vaps_checker u_vaps_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
